@@ design/est_pkg.sv @@
// Package for the easing setpoint trajectory block: widths, codes, control
// word layout and the microcode program. No dependencies.
package est_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ONE_W     = FRAC_BITS + 1;
  localparam int unsigned CNT_W     = $clog2(FRAC_BITS);
  localparam int unsigned A_W       = 33;
  localparam int unsigned MB_W      = FRAC_BITS + 5;
  localparam int unsigned PROD_W    = A_W + MB_W;
  localparam int unsigned ACC_W     = 33 + ONE_W;
  localparam int unsigned UPC_W     = 4;

  localparam logic [ONE_W-1:0] ONE_V = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_STOP   = 2'd1,
    OP_SAMPLE = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    CURVE_FLAT   = 2'd0,
    CURVE_LINEAR = 2'd1,
    CURVE_JERK   = 2'd2
  } curve_e;

  typedef enum logic [1:0] {
    CFG_CURVE_MODE    = 2'd0,
    CFG_MOVE_DURATION = 2'd1,
    CFG_START_VALUE   = 2'd2,
    CFG_TARGET_VALUE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    WR_NONE,
    WR_DIV_INIT,
    WR_DIV_STEP,
    WR_V_SEL,
    WR_T2,
    WR_T3,
    WR_V,
    WR_ACC_LD,
    WR_ACC_ADD,
    WR_OUT
  } wr_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_TT,
    MUL_T2T,
    MUL_T3P,
    MUL_SV,
    MUL_GV
  } mul_e;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_GE,
    JMP_CNT,
    JMP_NOT_JERK,
    JMP_END
  } jmp_e;

  typedef struct packed {
    wr_e              wr;
    mul_e             mul;
    jmp_e             jmp;
    logic [UPC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic   load;
    logic   zero;
    ucode_t uc;
  } dp_ctrl_t;

  typedef struct packed {
    logic ge;
    logic cnt_zero;
    logic jerk;
  } dp_stat_t;

  localparam logic [UPC_W-1:0] STEP_DIV_INIT = 4'd0;
  localparam logic [UPC_W-1:0] STEP_DIV_LOOP = 4'd1;
  localparam logic [UPC_W-1:0] STEP_CURVE    = 4'd2;
  localparam logic [UPC_W-1:0] STEP_BLEND    = 4'd8;
  localparam logic [UPC_W-1:0] STEP_FINISH   = 4'd11;

  localparam ucode_t UC_IDLE = '{wr: WR_NONE, mul: MUL_NONE, jmp: JMP_NEXT, target: '0};

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] step);
    ucode_t w;
    w = UC_IDLE;
    case (step)
      4'd0:  w = '{wr: WR_DIV_INIT, mul: MUL_NONE, jmp: JMP_GE,       target: STEP_CURVE};
      4'd1:  w = '{wr: WR_DIV_STEP, mul: MUL_NONE, jmp: JMP_CNT,      target: STEP_DIV_LOOP};
      4'd2:  w = '{wr: WR_V_SEL,    mul: MUL_TT,   jmp: JMP_NOT_JERK, target: STEP_BLEND};
      4'd3:  w = '{wr: WR_T2,       mul: MUL_NONE, jmp: JMP_NEXT,     target: '0};
      4'd4:  w = '{wr: WR_NONE,     mul: MUL_T2T,  jmp: JMP_NEXT,     target: '0};
      4'd5:  w = '{wr: WR_T3,       mul: MUL_NONE, jmp: JMP_NEXT,     target: '0};
      4'd6:  w = '{wr: WR_NONE,     mul: MUL_T3P,  jmp: JMP_NEXT,     target: '0};
      4'd7:  w = '{wr: WR_V,        mul: MUL_NONE, jmp: JMP_NEXT,     target: '0};
      4'd8:  w = '{wr: WR_NONE,     mul: MUL_SV,   jmp: JMP_NEXT,     target: '0};
      4'd9:  w = '{wr: WR_ACC_LD,   mul: MUL_GV,   jmp: JMP_NEXT,     target: '0};
      4'd10: w = '{wr: WR_ACC_ADD,  mul: MUL_NONE, jmp: JMP_NEXT,     target: '0};
      4'd11: w = '{wr: WR_OUT,      mul: MUL_NONE, jmp: JMP_END,      target: '0};
      default: w = UC_IDLE;
    endcase
    return w;
  endfunction

endpackage

@@ design/est_datapath.sv @@
// Datapath of the easing setpoint block: serial divider, shared multiplier,
// curve and blend registers. Driven one control word per cycle; uses est_pkg.
module est_datapath
  import est_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_ctrl_t           ctrl_i,
  input  logic [31:0]        elapsed_i,
  input  logic [1:0]         curve_mode_i,
  input  logic [30:0]        move_duration_i,
  input  logic signed [31:0] start_value_i,
  input  logic signed [31:0] target_value_i,
  output dp_stat_t           stat_o,
  output logic signed [31:0] result_o
);

  logic [31:0]              rem_q, rem_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [ONE_W-1:0]         t_q, t_d;
  logic [ONE_W-1:0]         t2_q, t2_d;
  logic [ONE_W-1:0]         t3_q, t3_d;
  logic [ONE_W-1:0]         v_q, v_d;
  logic                     zero_q, zero_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  logic [31:0]              dur_x;
  logic [31:0]              rem_dbl;
  logic                     step_ge;
  logic [MB_W-1:0]          t2_x, t_x, p_val;
  logic [ONE_W-1:0]         one_minus_v;
  logic signed [A_W-1:0]    mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [ACC_W-1:0]  prod_low;
  logic signed [ACC_W-1:0]  biased;

  assign dur_x   = {1'b0, move_duration_i};
  assign rem_dbl = {rem_q[30:0], 1'b0};
  assign step_ge = rem_dbl >= dur_x;

  assign t2_x  = MB_W'(t2_q);
  assign t_x   = MB_W'(t_q);
  assign p_val = (MB_W'(10) << FRAC_BITS) + (t2_x << 2) + (t2_x << 1) - (t_x << 4) + t_x;
  assign one_minus_v = ONE_V - v_q;

  assign stat_o.ge       = rem_q >= dur_x;
  assign stat_o.cnt_zero = cnt_q == '0;
  assign stat_o.jerk     = curve_mode_i == CURVE_JERK;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.uc.mul)
      MUL_TT: begin
        mul_a = $signed(A_W'(t_q));
        mul_b = $signed(MB_W'(t_q));
      end
      MUL_T2T: begin
        mul_a = $signed(A_W'(t2_q));
        mul_b = $signed(MB_W'(t_q));
      end
      MUL_T3P: begin
        mul_a = $signed(A_W'(t3_q));
        mul_b = $signed(p_val);
      end
      MUL_SV: begin
        mul_a = A_W'(start_value_i);
        mul_b = $signed(MB_W'(one_minus_v));
      end
      MUL_GV: begin
        mul_a = A_W'(target_value_i);
        mul_b = $signed(MB_W'(v_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d   = (ctrl_i.uc.mul == MUL_NONE) ? prod_q : PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_low = prod_q[ACC_W-1:0];

  always_comb begin
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    t_d    = t_q;
    t2_d   = t2_q;
    t3_d   = t3_q;
    v_d    = v_q;
    acc_d  = acc_q;
    zero_d = zero_q;
    if (ctrl_i.load) begin
      rem_d  = elapsed_i;
      zero_d = ctrl_i.zero;
    end
    case (ctrl_i.uc.wr)
      WR_DIV_INIT: begin
        cnt_d = CNT_W'(FRAC_BITS - 1);
        t_d   = stat_o.ge ? ONE_V : '0;
      end
      WR_DIV_STEP: begin
        rem_d = step_ge ? rem_dbl - dur_x : rem_dbl;
        t_d   = {t_q[FRAC_BITS-1:0], step_ge};
        cnt_d = cnt_q - 1'b1;
      end
      WR_V_SEL: begin
        case (curve_mode_i)
          CURVE_FLAT:   v_d = ONE_V;
          CURVE_LINEAR: v_d = t_q;
          default:      v_d = '0;
        endcase
      end
      WR_T2:      t2_d  = prod_q[FRAC_BITS +: ONE_W];
      WR_T3:      t3_d  = prod_q[FRAC_BITS +: ONE_W];
      WR_V:       v_d   = prod_q[FRAC_BITS +: ONE_W];
      WR_ACC_LD:  acc_d = prod_low;
      WR_ACC_ADD: acc_d = acc_q + prod_low;
      default: begin
      end
    endcase
  end

  // Division by ONE rounds toward zero, so negative sums get a bias first.
  assign biased   = acc_q + (acc_q[ACC_W-1] ? ACC_W'(ONE_V - 1'b1) : ACC_W'(0));
  assign result_o = zero_q ? 32'sd0 : biased[FRAC_BITS +: 32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      zero_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      zero_q <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    t_q    <= t_d;
    t2_q   <= t2_d;
    t3_q   <= t3_d;
    v_q    <= v_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

endmodule

@@ design/easing_setpoint_trajectory_top.sv @@
// Top level of the easing setpoint block: configuration registers, move
// state, microcode sequencer and output register. Uses est_pkg, est_datapath.
//
// Usage: a word on the input channel carries an opcode and the current time.
// Start records the time and arms the move, stop disarms it; both finish in
// the cycle they are accepted and give no result. A sample gives one result
// word on the output channel with the eased setpoint, or 0 when disarmed.
// Configuration registers are written through the cfg channel, which is
// always ready; the user must write them only while no sample is in flight, not enforced.
// Steps of a sample: a disarmed one goes straight to the finish step. An
// armed one runs the divider init step, then, during the move, the 16 step
// divider loop, which is skipped once the move is complete or the duration
// is 0; then the curve step, the jerk steps for the minimum jerk curve only,
// the blend steps and the finish step. All products share a single multiplier.
// The input is stalled while a sample is in work and is free again once
// its result enters the output register; start and stop words are taken
// one per cycle while no sample is in work.
// When the receiver stalls, the finished result waits in the sequencer's
// last step until the output register is free.
// Reset disarms the block and clears all configuration registers to 0.
module easing_setpoint_trajectory_top
  import est_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] now_ticks_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] setpoint_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [1:0]         curve_mode_q, curve_mode_d;
  logic [30:0]        move_duration_q, move_duration_d;
  logic signed [31:0] start_value_q, start_value_d;
  logic signed [31:0] target_value_q, target_value_d;
  logic               armed_q, armed_d;
  logic [31:0]        start_time_q, start_time_d;
  logic               busy_q, busy_d;
  logic [UPC_W-1:0]   upc_q, upc_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] setpoint_q, setpoint_d;

  logic               in_accept;
  logic               sample_go;
  logic               out_free;
  logic               out_load;
  ucode_t             uc;
  dp_ctrl_t           dp_ctrl;
  dp_stat_t           dp_stat;
  logic signed [31:0] dp_result;
  logic [31:0]        elapsed;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign setpoint_o  = setpoint_q;

  assign in_accept = in_valid_i && !in_stall_o;
  assign sample_go = in_accept && (opcode_i == OP_SAMPLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign uc        = busy_q ? ucode_rom(upc_q) : UC_IDLE;
  assign out_load  = busy_q && (uc.jmp == JMP_END) && out_free;
  assign elapsed   = now_ticks_i - start_time_q;

  assign dp_ctrl.load = sample_go;
  assign dp_ctrl.zero = !armed_q;
  assign dp_ctrl.uc   = uc;

  est_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (dp_ctrl),
    .elapsed_i       (elapsed),
    .curve_mode_i    (curve_mode_q),
    .move_duration_i (move_duration_q),
    .start_value_i   (start_value_q),
    .target_value_i  (target_value_q),
    .stat_o          (dp_stat),
    .result_o        (dp_result)
  );

  always_comb begin
    curve_mode_d    = curve_mode_q;
    move_duration_d = move_duration_q;
    start_value_d   = start_value_q;
    target_value_d  = target_value_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CURVE_MODE:    curve_mode_d    = cfg_data_i[1:0];
        CFG_MOVE_DURATION: move_duration_d = cfg_data_i[30:0];
        CFG_START_VALUE:   start_value_d   = cfg_data_i;
        CFG_TARGET_VALUE:  target_value_d  = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    armed_d      = armed_q;
    start_time_d = start_time_q;
    if (in_accept) begin
      case (opcode_i)
        OP_START: begin
          armed_d      = 1'b1;
          start_time_d = now_ticks_i;
        end
        OP_STOP: armed_d = 1'b0;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    busy_d = busy_q;
    upc_d  = upc_q;
    if (sample_go) begin
      busy_d = 1'b1;
      upc_d  = armed_q ? STEP_DIV_INIT : STEP_FINISH;
    end else if (busy_q) begin
      case (uc.jmp)
        JMP_GE:       upc_d = dp_stat.ge ? uc.target : upc_q + 1'b1;
        JMP_CNT:      upc_d = !dp_stat.cnt_zero ? uc.target : upc_q + 1'b1;
        JMP_NOT_JERK: upc_d = !dp_stat.jerk ? uc.target : upc_q + 1'b1;
        JMP_END:      busy_d = !out_free;
        default:      upc_d = upc_q + 1'b1;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    setpoint_d  = setpoint_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      setpoint_d  = dp_result;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_mode_q    <= '0;
      move_duration_q <= '0;
      start_value_q   <= '0;
      target_value_q  <= '0;
      armed_q         <= 1'b0;
      start_time_q    <= '0;
      busy_q          <= 1'b0;
      upc_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      curve_mode_q    <= curve_mode_d;
      move_duration_q <= move_duration_d;
      start_value_q   <= start_value_d;
      target_value_q  <= target_value_d;
      armed_q         <= armed_d;
      start_time_q    <= start_time_d;
      busy_q          <= busy_d;
      upc_q           <= upc_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    setpoint_q <= setpoint_d;
  end

endmodule
